[rtl/expression_tokenizer_top_macros.svh]
// assertion macros for the expression tokenizer
`ifndef EXPRESSION_TOKENIZER_TOP_MACROS_SVH
`define EXPRESSION_TOKENIZER_TOP_MACROS_SVH

// same-cycle implication
`define ETOK_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ETOK_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/etok_pkg.sv]
`timescale 1ns / 1ps

package etok_pkg;

   localparam int MAX_DIGITS  = 10;
   localparam int TOKEN_DEPTH = 11;
   localparam int IDX_W       = $clog2(TOKEN_DEPTH);
   localparam int LEN_W       = $clog2(TOKEN_DEPTH + 1);
   localparam int DC_W        = $clog2(MAX_DIGITS + 1);

   localparam logic [1:0] ITEM_TOKEN = 2'd0;
   localparam logic [1:0] ITEM_END   = 2'd1;
   localparam logic [1:0] ITEM_ERROR = 2'd2;

   localparam logic [7:0] CH_MINUS  = 8'h2d;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_PLUS   = 8'h2b;
   localparam logic [7:0] CH_STAR   = 8'h2a;
   localparam logic [7:0] CH_SLASH  = 8'h2f;
   localparam logic [7:0] CH_EQUAL  = 8'h3d;

   typedef logic [7:0] char_type;

endpackage

[rtl/expression_tokenizer_top.sv]
`timescale 1ns / 1ps

// Expression tokenizer. Takes one ASCII character per request (req_tlast on the final
// character of an expression) and returns the tokens character by character: ( ) + * / =
// are single tokens, '-' opens a token and joins the following number as its sign when a
// unary minus is allowed, everything else gathers into a number. Each response carries the
// character, an item kind (token character, end of expression, too-many-digits error), a
// token-end flag, and rsp_tlast on the last response caused by a request. A small
// sequencer walks each character through decide, flush, operator, append and tail steps,
// with one buffer index counter that reads the pending token out one entry a cycle while
// the response side is not stalled; the block takes no new request meanwhile.

module expression_tokenizer_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_char
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic [2:0] rsp_tuser,   // [1:0] item_type, [2] token_end
   output logic       rsp_tlast
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECIDE = 3'd1;
   localparam logic [2:0] ST_ERR    = 3'd2;
   localparam logic [2:0] ST_FLUSH1 = 3'd3;
   localparam logic [2:0] ST_OP     = 3'd4;
   localparam logic [2:0] ST_APPEND = 3'd5;
   localparam logic [2:0] ST_TAIL   = 3'd6;
   localparam logic [2:0] ST_FLUSH2 = 3'd7;

   logic [2:0]                 state_ff, state_in;
   etok_pkg::char_type         ch_ff, ch_in;
   logic                       last_ff, last_in;
   etok_pkg::char_type         buf_ff [etok_pkg::TOKEN_DEPTH];
   logic [etok_pkg::LEN_W-1:0] len_ff, len_in;
   logic [etok_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic                       am_ff, am_in;
   logic                       ua_ff, ua_in;
   logic [etok_pkg::DC_W-1:0]  dc_ff, dc_in;
   logic                       err_ff, err_in;
   logic                       op_ff, op_in;
   logic                       end_pend_ff, end_pend_in;
   logic                       rsp_tvalid_ff, rsp_tvalid_in;
   etok_pkg::char_type         rsp_char_ff, rsp_char_in;
   logic [1:0]                 rsp_type_ff, rsp_type_in;
   logic                       rsp_end_ff, rsp_end_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       buf_we;
   logic                       out_free;
   logic                       emit;
   logic                       is_minus;
   logic                       is_op;
   logic                       flush_go;
   logic                       op_go;
   logic                       app_go;
   logic                       idx_at_end;
   etok_pkg::char_type         buf_rd;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tuser  = {rsp_end_ff, rsp_type_ff};
   assign rsp_tlast  = rsp_last_ff;

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign is_minus   = (ch_ff == etok_pkg::CH_MINUS);
   assign is_op      = (ch_ff == etok_pkg::CH_LPAREN) || (ch_ff == etok_pkg::CH_RPAREN) ||
                       (ch_ff == etok_pkg::CH_PLUS)   || (ch_ff == etok_pkg::CH_STAR)   ||
                       (ch_ff == etok_pkg::CH_SLASH)  || (ch_ff == etok_pkg::CH_EQUAL);
   assign buf_rd     = buf_ff[idx_ff];
   assign idx_at_end = ((etok_pkg::LEN_W'(idx_ff) + etok_pkg::LEN_W'(1)) == len_ff);

   always_comb begin
      state_in    = state_ff;
      ch_in       = ch_ff;
      last_in     = last_ff;
      len_in      = len_ff;
      idx_in      = idx_ff;
      am_in       = am_ff;
      ua_in       = ua_ff;
      dc_in       = dc_ff;
      err_in      = err_ff;
      op_in       = op_ff;
      end_pend_in = end_pend_ff;
      buf_we      = 1'b0;
      flush_go    = 1'b0;
      op_go       = 1'b0;
      app_go      = 1'b0;
      emit        = 1'b0;
      rsp_char_in = '0;
      rsp_type_in = etok_pkg::ITEM_TOKEN;
      rsp_end_in  = 1'b0;
      rsp_last_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               ch_in       = req_tdata;
               last_in     = req_tlast;
               end_pend_in = 1'b0;
               state_in    = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            idx_in = '0;
            if (err_ff) begin
               state_in = ST_TAIL;
            end else if (dc_ff >= etok_pkg::DC_W'(etok_pkg::MAX_DIGITS)) begin
               err_in   = 1'b1;
               len_in   = '0;
               state_in = ST_ERR;
            end else begin
               if (is_minus) begin
                  dc_in  = '0;
                  am_in  = 1'b1;
                  app_go = 1'b1;
                  if (len_ff != '0) begin
                     flush_go = 1'b1;
                     ua_in    = 1'b0;
                  end
               end else if (is_op) begin
                  dc_in = '0;
                  op_go = 1'b1;
                  if (am_ff) begin
                     am_in = 1'b0;
                     if (len_ff != '0) begin
                        flush_go = 1'b1;
                        ua_in    = 1'b1;
                     end
                  end else begin
                     ua_in = (ch_ff == etok_pkg::CH_LPAREN);
                     if (len_ff != '0) begin
                        flush_go = 1'b1;
                     end
                  end
               end else begin
                  dc_in  = dc_ff + etok_pkg::DC_W'(1);
                  app_go = 1'b1;
                  if (am_ff && ua_ff) begin
                     ua_in = 1'b0;
                  end else if (am_ff && (len_ff == etok_pkg::LEN_W'(1)) &&
                               (buf_ff[0] == etok_pkg::CH_MINUS)) begin
                     flush_go = 1'b1;
                  end
               end
               op_in = op_go;
               if (flush_go) begin
                  state_in = ST_FLUSH1;
               end else if (op_go) begin
                  state_in = ST_OP;
               end else if (app_go) begin
                  state_in = ST_APPEND;
               end else begin
                  state_in = ST_TAIL;
               end
            end
         end
         ST_ERR: begin
            emit        = 1'b1;
            rsp_type_in = etok_pkg::ITEM_ERROR;
            rsp_last_in = !last_ff;
            if (out_free) begin
               state_in = ST_TAIL;
            end
         end
         ST_FLUSH1: begin
            emit        = 1'b1;
            rsp_char_in = buf_rd;
            rsp_end_in  = idx_at_end;
            rsp_last_in = idx_at_end && !op_ff && !last_ff;
            if (out_free) begin
               if (idx_at_end) begin
                  len_in   = '0;
                  state_in = op_ff ? ST_OP : ST_APPEND;
               end else begin
                  idx_in = idx_ff + etok_pkg::IDX_W'(1);
               end
            end
         end
         ST_OP: begin
            emit        = 1'b1;
            rsp_char_in = ch_ff;
            rsp_end_in  = 1'b1;
            rsp_last_in = !last_ff;
            if (out_free) begin
               state_in = ST_TAIL;
            end
         end
         ST_APPEND: begin
            if (len_ff < etok_pkg::LEN_W'(etok_pkg::TOKEN_DEPTH)) begin
               buf_we = 1'b1;
               len_in = len_ff + etok_pkg::LEN_W'(1);
            end
            state_in = ST_TAIL;
         end
         ST_TAIL: begin
            idx_in = '0;
            if (end_pend_ff) begin
               emit        = 1'b1;
               rsp_type_in = etok_pkg::ITEM_END;
               rsp_last_in = 1'b1;
               if (out_free) begin
                  len_in   = '0;
                  am_in    = 1'b0;
                  ua_in    = 1'b1;
                  dc_in    = '0;
                  err_in   = 1'b0;
                  state_in = ST_IDLE;
               end
            end else if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (!err_ff && (len_ff != '0)) begin
               state_in = ST_FLUSH2;
            end else begin
               end_pend_in = 1'b1;
            end
         end
         ST_FLUSH2: begin
            emit        = 1'b1;
            rsp_char_in = buf_rd;
            rsp_end_in  = idx_at_end;
            if (out_free) begin
               if (idx_at_end) begin
                  len_in      = '0;
                  end_pend_in = 1'b1;
                  state_in    = ST_TAIL;
               end else begin
                  idx_in = idx_ff + etok_pkg::IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (emit && out_free) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         len_ff        <= '0;
         idx_ff        <= '0;
         am_ff         <= 1'b0;
         ua_ff         <= 1'b1;
         dc_ff         <= '0;
         err_ff        <= 1'b0;
         op_ff         <= 1'b0;
         end_pend_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         len_ff        <= len_in;
         idx_ff        <= idx_in;
         am_ff         <= am_in;
         ua_ff         <= ua_in;
         dc_ff         <= dc_in;
         err_ff        <= err_in;
         op_ff         <= op_in;
         end_pend_ff   <= end_pend_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff   <= ch_in;
      last_ff <= last_in;
      if (buf_we) begin
         buf_ff[len_ff[etok_pkg::IDX_W-1:0]] <= ch_ff;
      end
      if (emit && out_free) begin
         rsp_char_ff <= rsp_char_in;
         rsp_type_ff <= rsp_type_in;
         rsp_end_ff  <= rsp_end_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

endmodule

[rtl/etok_checker.sv]
`timescale 1ns / 1ps
`include "expression_tokenizer_top_macros.svh"

module etok_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,   // [7:0] out_char
   input logic [2:0] rsp_tuser,   // [1:0] item_type, [2] token_end
   input logic       rsp_tlast
);

   // stalled response holds
   `ETOK_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast),
      "stalled response changed")

   // one character at a time
   `ETOK_ASSERT_NEXT(a_req_busy, req_tvalid && req_tready, !req_tready,
      "request taken while busy")

   `ETOK_ASSERT_NOW(a_end_item, rsp_tvalid && rsp_tuser[1:0] == etok_pkg::ITEM_END,
      rsp_tlast && rsp_tdata == 8'd0 && !rsp_tuser[2], "malformed end item")

   `ETOK_ASSERT_NOW(a_err_item, rsp_tvalid && rsp_tuser[1:0] == etok_pkg::ITEM_ERROR,
      rsp_tdata == 8'd0 && !rsp_tuser[2], "malformed error item")

   `ETOK_ASSERT_NOW(a_kind, rsp_tvalid,
      (rsp_tuser[1:0] <= etok_pkg::ITEM_ERROR) &&
      (rsp_tuser[1:0] == etok_pkg::ITEM_TOKEN || !rsp_tuser[2]), "bad item kind")

endmodule

bind expression_tokenizer_top etok_checker u_etok_checker (.*);

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import etok_pkg::*;

   localparam int RESULT_CAP   = 13;
   localparam int RANDOM_ITEMS = 205;

   typedef struct packed {
      logic [1:0] kind;
      char_type   ch;
      logic       tok_end;
      logic       run_end;
   } tok_result_type;

   typedef struct {
      char_type       ch;
      logic           last;
      int             n_typed;
      tok_result_type typed[2];
   } char_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] in_char
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_char
   logic [2:0] rsp_tuser;           // [1:0] item_type, [2] token_end
   logic       rsp_tlast;

   expression_tokenizer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // tokenizer state as predicted
   char_type    tok_buf[TOKEN_DEPTH];
   int unsigned tok_len;
   int unsigned run_digits;
   bit          seen_minus;
   bit          sign_ok;
   bit          in_error;

   tok_result_type step_out[$];
   tok_result_type awaited_tokens[$];
   char_row_type   directed_rows[$];

   bit calm = 1'b0;
   bit drained = 1'b0;
   int hold_off = 0;
   int stall_len;
   int mismatches = 0;
   int responses = 0;
   int errors_seen = 0;
   int sent = 0;
   int expressions = 0;

   function automatic tok_result_type mk(logic [1:0] kind, char_type ch, logic tok_end,
                                         logic run_end);
      tok_result_type r;
      r.kind = kind;
      r.ch = ch;
      r.tok_end = tok_end;
      r.run_end = run_end;
      return r;
   endfunction

   function automatic void put_item(logic [1:0] kind, char_type ch, logic tok_end);
      if (step_out.size() >= RESULT_CAP) return;
      step_out.push_back(mk(kind, ch, tok_end, 1'b0));
   endfunction

   function automatic void flush_pending();
      for (int i = 0; i < tok_len && i < TOKEN_DEPTH; i++)
         put_item(ITEM_TOKEN, tok_buf[i], (i + 1 == tok_len));
      tok_len = 0;
   endfunction

   function automatic void add_char(char_type c);
      if (tok_len < TOKEN_DEPTH) begin
         tok_buf[tok_len] = c;
         tok_len++;
      end
   endfunction

   function automatic bit is_op(char_type c);
      return c == CH_LPAREN || c == CH_RPAREN || c == CH_PLUS || c == CH_STAR ||
             c == CH_SLASH || c == CH_EQUAL;
   endfunction

   function automatic void clear_expression();
      tok_len = 0;
      seen_minus = 1'b0;
      sign_ok = 1'b1;
      run_digits = 0;
      in_error = 1'b0;
   endfunction

   function automatic void take_char(char_type c);
      if (c == CH_MINUS) begin
         run_digits = 0;
         seen_minus = 1'b1;
         if (tok_len != 0) begin
            flush_pending();
            sign_ok = 1'b0;
         end
         add_char(c);
      end else if (is_op(c)) begin
         run_digits = 0;
         if (seen_minus) begin
            seen_minus = 1'b0;
            if (tok_len != 0) begin
               flush_pending();
               sign_ok = 1'b1;
            end
         end else begin
            sign_ok = (c == CH_LPAREN);
            if (tok_len != 0) flush_pending();
         end
         put_item(ITEM_TOKEN, c, 1'b1);
      end else begin
         if (run_digits < 15) run_digits++;
         // a lone binary minus goes out before the number that follows it
         if (seen_minus && !sign_ok && tok_len == 1 && tok_buf[0] == CH_MINUS)
            flush_pending();
         else if (seen_minus && sign_ok)
            sign_ok = 1'b0;
         add_char(c);
      end
   endfunction

   function automatic void tokenize_char(char_type c, logic last);
      step_out.delete();
      if (!in_error) begin
         if (run_digits >= MAX_DIGITS) begin
            put_item(ITEM_ERROR, 8'h00, 1'b0);
            in_error = 1'b1;
            tok_len = 0;
         end else begin
            take_char(c);
         end
      end
      if (last) begin
         if (!in_error) flush_pending();
         put_item(ITEM_END, 8'h00, 1'b0);
         clear_expression();
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].run_end = 1'b1;
   endfunction

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic add_row(char_type ch, logic last, int n_typed, tok_result_type t0,
                          tok_result_type t1);
      char_row_type row;
      row.ch = ch;
      row.last = last;
      row.n_typed = n_typed;
      row.typed[0] = t0;
      row.typed[1] = t1;
      directed_rows.push_back(row);
   endtask

   task automatic push_char(char_row_type row);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      tokenize_char(row.ch, row.last);
      if (row.n_typed == 0) begin
         foreach (step_out[i]) awaited_tokens.push_back(step_out[i]);
      end else begin
         for (int i = 0; i < row.n_typed; i++) awaited_tokens.push_back(row.typed[i]);
      end
      req_tvalid <= 1'b1;
      req_tdata <= row.ch;
      req_tlast <= row.last;
      do @(posedge clock); while (!req_tready);
      sent++;
      if (row.last) expressions++;
   endtask

   task automatic send_expression();
      char_type     ops[6];
      char_type     chars[$];
      char_row_type row;
      int           n_tok;
      int           run;
      int           r;
      ops = '{CH_LPAREN, CH_RPAREN, CH_PLUS, CH_STAR, CH_SLASH, CH_EQUAL};
      n_tok = $urandom_range(1, 8);
      for (int t = 0; t < n_tok; t++) begin
         r = $urandom_range(0, 99);
         if (r < 50) begin
            // number run, sometimes just below, at or past the digit limit
            if ($urandom_range(0, 9) < 2) run = $urandom_range(MAX_DIGITS - 1, MAX_DIGITS + 1);
            else run = $urandom_range(1, 4);
            for (int k = 0; k < run; k++) begin
               if ($urandom_range(0, 4) != 0)
                  chars.push_back(char_type'(8'h30 + $urandom_range(0, 9)));
               else
                  chars.push_back(char_type'($urandom_range(0, 255)));
            end
         end else if (r < 80) begin
            chars.push_back(ops[$urandom_range(0, 5)]);
         end else if (r < 95) begin
            chars.push_back(CH_MINUS);
         end else begin
            chars.push_back(char_type'($urandom_range(0, 255)));
         end
      end
      calm = ($urandom_range(0, 5) == 0);
      foreach (chars[i]) begin
         row.ch = chars[i];
         row.last = (i == chars.size() - 1);
         row.n_typed = 0;
         push_char(row);
      end
   endtask

   // response side: random back-pressure
   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else begin
         stall_len = pick_gap();
         if (stall_len > 0) begin
            hold_off <= stall_len - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      tok_result_type want;
      tok_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = mk(rsp_tuser[1:0], rsp_tdata, rsp_tuser[2], rsp_tlast);
         responses++;
         if (got.kind == ITEM_ERROR) errors_seen++;
         if (awaited_tokens.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t unexpected response kind=%0d ch=%02h end=%0b last=%0b",
                        $time, got.kind, got.ch, got.tok_end, got.run_end);
         end else begin
            want = awaited_tokens.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t mismatch: expected kind=%0d ch=%02h end=%0b last=%0b, %s",
                           $time, want.kind, want.ch, want.tok_end, want.run_end,
                           $sformatf("got kind=%0d ch=%02h end=%0b last=%0b",
                                     got.kind, got.ch, got.tok_end, got.run_end));
            end
         end
      end
   end

   initial begin
      #5ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      tok_result_type none;
      none = mk(ITEM_TOKEN, 8'h00, 1'b0, 1'b0);
      clear_expression();

      // signed number in parentheses
      add_row(CH_LPAREN, 1'b0, 1, mk(ITEM_TOKEN, CH_LPAREN, 1'b1, 1'b1), none);
      add_row(CH_MINUS, 1'b0, 0, none, none);
      add_row("7", 1'b0, 0, none, none);
      add_row(CH_RPAREN, 1'b0, 0, none, none);
      add_row(CH_STAR, 1'b1, 0, none, none);
      // byte extremes as single-character expressions
      add_row(8'hff, 1'b1, 2, mk(ITEM_TOKEN, 8'hff, 1'b1, 1'b0), mk(ITEM_END, 8'h00, 1'b0, 1'b1));
      add_row(8'h00, 1'b1, 2, mk(ITEM_TOKEN, 8'h00, 1'b1, 1'b0), mk(ITEM_END, 8'h00, 1'b0, 1'b1));
      // full digit run, then one more character raises the error
      for (int i = 0; i < MAX_DIGITS; i++) add_row(char_type'(8'h30 + i), 1'b0, 0, none, none);
      add_row(CH_MINUS, 1'b0, 1, mk(ITEM_ERROR, 8'h00, 1'b0, 1'b1), none);
      add_row("5", 1'b1, 1, mk(ITEM_END, 8'h00, 1'b0, 1'b1), none);
      // two minus signs in a row; the second does not join the following number as its sign
      add_row("a", 1'b0, 0, none, none);
      add_row(CH_MINUS, 1'b0, 0, none, none);
      add_row(CH_MINUS, 1'b0, 0, none, none);
      add_row("b", 1'b0, 0, none, none);
      add_row(CH_PLUS, 1'b0, 0, none, none);
      add_row(CH_SLASH, 1'b0, 0, none, none);
      add_row(CH_EQUAL, 1'b1, 0, none, none);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      calm = 1'b1;
      foreach (directed_rows[i]) push_char(directed_rows[i]);

      while (sent < directed_rows.size() + RANDOM_ITEMS) begin
         send_expression();
         if (!drained && sent >= directed_rows.size() + RANDOM_ITEMS / 2) begin
            // drain everything before going on
            drained = 1'b1;
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (awaited_tokens.size() != 0) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;
      calm = 1'b0;

      while (awaited_tokens.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("run covered %0d requests in %0d expressions", sent, expressions);
      $display("%0d responses checked, %0d digit-limit errors, %0d mismatches",
               responses, errors_seen, mismatches);
      if (mismatches == 0 && awaited_tokens.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
